### src/spimrb_pkg.sv
// shared constants, types and decode helpers for the spi master register block
package spimrb_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int IDX_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [11:0] OFF_VERSION = 12'h000;
    localparam logic [11:0] OFF_PARAM   = 12'h004;
    localparam logic [11:0] OFF_CR      = 12'h010;
    localparam logic [11:0] OFF_SR      = 12'h014;
    localparam logic [11:0] OFF_IER     = 12'h018;
    localparam logic [11:0] OFF_QSR     = 12'h05C;
    localparam logic [11:0] OFF_TDR     = 12'h064;
    localparam logic [11:0] OFF_RSR     = 12'h070;
    localparam logic [11:0] OFF_RDR     = 12'h074;

    localparam logic [31:0] VERSION_VAL = 32'h0200_0004;
    localparam logic [31:0] PARAM_VAL   = 32'h0008_0202;
    localparam logic [31:0] RSR_VAL     = 32'h0000_0002;
    localparam logic [31:0] EMPTY_READ  = 32'hFFFF_FFFF;
    localparam logic [31:0] SR_RESET    = 32'h0000_0001;
    localparam logic [31:0] TCR_RESET   = 32'h0000_001F;

    localparam int CR_EN_BIT  = 0;
    localparam int CR_RST_BIT = 1;

    localparam logic [31:0] ST_WORD  = 32'h0000_0100;
    localparam logic [31:0] ST_FRAME = 32'h0000_0200;
    localparam logic [31:0] ST_TXOVF = 32'h0000_0800;
    localparam logic [31:0] ST_RXERR = 32'h0000_1000;

    localparam int NPLAIN   = 10;
    localparam int PLAIN_W  = $clog2(NPLAIN);
    localparam int PLAIN_TCR = 9;

    typedef struct packed {
        logic               hit;
        logic [PLAIN_W-1:0] idx;
    } t_plain_sel;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic drain;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
        logic drain_start;
        logic tx_last;
    } t_dp_status;

    function automatic t_plain_sel plain_slot(input logic [11:0] off);
        t_plain_sel s;
        s.hit = 1'b1;
        s.idx = '0;
        unique case (off)
            12'h01C: s.idx = PLAIN_W'(0);
            12'h020: s.idx = PLAIN_W'(1);
            12'h024: s.idx = PLAIN_W'(2);
            12'h030: s.idx = PLAIN_W'(3);
            12'h034: s.idx = PLAIN_W'(4);
            12'h040: s.idx = PLAIN_W'(5);
            12'h044: s.idx = PLAIN_W'(6);
            12'h058: s.idx = PLAIN_W'(7);
            12'h05C, 12'h000: s.hit = 1'b0;
            12'h060: s.idx = PLAIN_W'(PLAIN_TCR);
            default: s.hit = 1'b0;
        endcase
        return s;
    endfunction

endpackage

### src/spi_master_register_block.sv
// top level of the spi master register block
// Each bus access is one input word. It is taken in a cycle where the block
// is idle, enters the execute state in the next cycle and executes once the
// output register is free. An access without a transmit drain loads its single
// result as it executes and returns the block to idle. A transmit-data write
// while enabled drains the whole transmit queue through the drain sequencer,
// one word per cycle while the output register is free, with one result per
// word, counting the new word (up to the queue depth of 4). Results sit in an
// output register, so a stalled consumer only holds the next execute or drain
// step. The interrupt level in every result is the level after the whole access.
module spi_master_register_block (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [11:0] i_offset,
    input  logic [31:0] i_write_data,
    input  logic [31:0] i_slave_reply,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_read_data,
    output logic        o_spi_valid,
    output logic [31:0] o_spi_word,
    output logic        o_irq_line,
    output logic        o_last
);
    import spimrb_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    spimrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    spimrb_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_command     (i_command),
        .i_offset      (i_offset),
        .i_write_data  (i_write_data),
        .i_slave_reply (i_slave_reply),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_read_data   (o_read_data),
        .o_spi_valid   (o_spi_valid),
        .o_spi_word    (o_spi_word),
        .o_irq_line    (o_irq_line),
        .o_last        (o_last)
    );

endmodule

### src/spimrb_ctrl.sv
// sequencing state machine: accept, execute, drain transmit queue
module spimrb_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  spimrb_pkg::t_dp_status i_status,
    output logic                   o_in_ready,
    output spimrb_pkg::t_ctrl_cmd  o_cmd
);
    import spimrb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_status.out_free) n_state = i_status.drain_start ? S_DRAIN : S_IDLE;
            end
            S_DRAIN: begin
                if (i_status.out_free && i_status.tx_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cmd.load_item = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec      = (r_state == S_EXEC);
    assign o_cmd.drain     = (r_state == S_DRAIN);

endmodule

### src/spimrb_dpath.sv
// register file, transmit and receive queues, and result word register
module spimrb_dpath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  spimrb_pkg::t_ctrl_cmd  i_cmd,
    output spimrb_pkg::t_dp_status o_status,
    input  logic                   i_command,
    input  logic [11:0]            i_offset,
    input  logic [31:0]            i_write_data,
    input  logic [31:0]            i_slave_reply,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [31:0]            o_read_data,
    output logic                   o_spi_valid,
    output logic [31:0]            o_spi_word,
    output logic                   o_irq_line,
    output logic                   o_last
);
    import spimrb_pkg::*;

    logic              r_cmd;
    logic [11:0]       r_off;
    logic [31:0]       r_wdata;
    logic [31:0]       r_reply;

    logic [31:0]       r_cr, n_cr;
    logic [31:0]       r_sr, n_sr;
    logic [31:0]       r_ier, n_ier;
    logic [31:0]       r_plain [NPLAIN];
    logic [31:0]       n_plain [NPLAIN];
    logic [CNT_W-1:0]  r_tx_count, n_tx_count;
    logic [CNT_W-1:0]  r_rx_count, n_rx_count;
    logic [31:0]       r_tx_q [FIFO_DEPTH];
    logic [31:0]       r_rx_q [FIFO_DEPTH];

    logic              r_out_valid;
    logic [31:0]       r_out_rdata;
    logic              r_out_spi_valid;
    logic [31:0]       r_out_spi_word;
    logic              r_out_irq;
    logic              r_out_last;

    logic              out_free;
    logic              exec_go;
    logic              drain_go;
    logic              load_out;
    logic              drain_start;
    logic              tx_push;
    logic              tx_pop;
    logic              rx_push;
    logic              rx_pop;
    logic              soft_rst;
    logic [31:0]       rdata;
    logic [CNT_W:0]    rx_need;
    t_plain_sel        sel;

    assign out_free = !r_out_valid || i_out_ready;
    assign exec_go  = i_cmd.exec && out_free;
    assign drain_go = i_cmd.drain && out_free;
    assign sel      = plain_slot(r_off);

    assign drain_start = (r_cmd == CMD_WRITE) && (r_off == OFF_TDR)
                         && (r_tx_count < CNT_W'(FIFO_DEPTH)) && r_cr[CR_EN_BIT];
    assign rx_need = {1'b0, r_rx_count} + {1'b0, r_tx_count} + (CNT_W+1)'(1);

    always_comb begin
        n_cr       = r_cr;
        n_sr       = r_sr;
        n_ier      = r_ier;
        n_plain    = r_plain;
        n_tx_count = r_tx_count;
        n_rx_count = r_rx_count;
        rdata      = '0;
        tx_push    = 1'b0;
        tx_pop     = 1'b0;
        rx_push    = 1'b0;
        rx_pop     = 1'b0;
        soft_rst   = 1'b0;
        if (exec_go) begin
            if (r_cmd == CMD_READ) begin
                if (r_off == OFF_VERSION) begin
                    rdata = VERSION_VAL;
                end else if (r_off == OFF_PARAM) begin
                    rdata = PARAM_VAL;
                end else if (r_off == OFF_RSR) begin
                    rdata = RSR_VAL;
                end else if (r_off == OFF_QSR) begin
                    rdata = (32'(r_rx_count) << 16) | 32'(r_tx_count);
                end else if (r_off == OFF_RDR) begin
                    if (r_rx_count != '0) begin
                        rdata      = r_rx_q[0];
                        rx_pop     = 1'b1;
                        n_rx_count = r_rx_count - CNT_W'(1);
                    end else begin
                        rdata = EMPTY_READ;
                        n_sr  = r_sr | ST_RXERR;
                    end
                end else if (r_off == OFF_CR) begin
                    rdata = r_cr;
                end else if (r_off == OFF_SR) begin
                    rdata = r_sr;
                end else if (r_off == OFF_IER) begin
                    rdata = r_ier;
                end else if (sel.hit) begin
                    rdata = r_plain[sel.idx];
                end
            end else begin
                if (r_off == OFF_CR) begin
                    n_cr     = r_wdata;
                    soft_rst = r_wdata[CR_RST_BIT];
                end else if (r_off == OFF_SR) begin
                    n_sr = r_sr & ~r_wdata;
                end else if (r_off == OFF_IER) begin
                    n_ier = r_wdata;
                end else if (r_off == OFF_TDR) begin
                    if (r_tx_count < CNT_W'(FIFO_DEPTH)) begin
                        tx_push    = 1'b1;
                        n_tx_count = r_tx_count + CNT_W'(1);
                        if (r_cr[CR_EN_BIT]) begin
                            n_sr = r_sr | ST_WORD | ST_FRAME;
                            if (rx_need > (CNT_W+1)'(FIFO_DEPTH)) n_sr = n_sr | ST_RXERR;
                        end
                    end else begin
                        n_sr = r_sr | ST_TXOVF;
                    end
                end else if (sel.hit) begin
                    n_plain[sel.idx] = r_wdata;
                end
            end
        end
        if (drain_go) begin
            tx_pop     = 1'b1;
            n_tx_count = r_tx_count - CNT_W'(1);
            if (r_rx_count < CNT_W'(FIFO_DEPTH)) begin
                rx_push    = 1'b1;
                n_rx_count = r_rx_count + CNT_W'(1);
            end
        end
        if (soft_rst) begin
            n_cr       = '0;
            n_sr       = SR_RESET;
            n_ier      = '0;
            n_tx_count = '0;
            n_rx_count = '0;
            for (int i = 0; i < NPLAIN; i++) begin
                n_plain[i] = (i == PLAIN_TCR) ? TCR_RESET : '0;
            end
        end
    end

    assign load_out = (exec_go && !drain_start) || drain_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr       <= '0;
            r_sr       <= SR_RESET;
            r_ier      <= '0;
            r_tx_count <= '0;
            r_rx_count <= '0;
            for (int i = 0; i < NPLAIN; i++) begin
                r_plain[i] <= (i == PLAIN_TCR) ? TCR_RESET : '0;
            end
        end else begin
            r_cr       <= n_cr;
            r_sr       <= n_sr;
            r_ier      <= n_ier;
            r_tx_count <= n_tx_count;
            r_rx_count <= n_rx_count;
            r_plain    <= n_plain;
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd   <= i_command;
            r_off   <= i_offset;
            r_wdata <= i_write_data;
            r_reply <= i_slave_reply;
        end
    end

    // shifting queues, head at entry 0
    always_ff @(posedge i_clk) begin
        if (tx_push) begin
            r_tx_q[r_tx_count[IDX_W-1:0]] <= r_wdata;
        end else if (tx_pop) begin
            for (int i = 0; i < FIFO_DEPTH - 1; i++) begin
                r_tx_q[i] <= r_tx_q[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_push) begin
            r_rx_q[r_rx_count[IDX_W-1:0]] <= r_reply;
        end else if (rx_pop) begin
            for (int i = 0; i < FIFO_DEPTH - 1; i++) begin
                r_rx_q[i] <= r_rx_q[i+1];
            end
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_rdata     <= drain_go ? '0 : rdata;
            r_out_spi_valid <= drain_go;
            r_out_spi_word  <= drain_go ? r_tx_q[0] : '0;
            r_out_irq       <= |(n_sr & n_ier);
            r_out_last      <= drain_go ? (r_tx_count == CNT_W'(1)) : 1'b1;
        end
    end

    assign o_status.out_free    = out_free;
    assign o_status.drain_start = drain_start;
    assign o_status.tx_last     = (r_tx_count == CNT_W'(1));

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_rdata;
    assign o_spi_valid = r_out_spi_valid;
    assign o_spi_word  = r_out_spi_word;
    assign o_irq_line  = r_out_irq;
    assign o_last      = r_out_last;

    a_tx_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_count <= CNT_W'(FIFO_DEPTH))
        else $error("transmit count beyond queue depth");

    a_rx_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_count <= CNT_W'(FIFO_DEPTH))
        else $error("receive count beyond queue depth");

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.drain |-> r_tx_count != '0)
        else $error("drain step with empty transmit queue");

    a_plain_result_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_spi_valid) |-> r_out_last)
        else $error("non-shift result not marked last");

endmodule
